// ----- src/csof_pkg.sv -----
// ----------------------------------------------------------------------------
// csof_pkg
// shared types and constants of the seed overlap fitness block
// ----------------------------------------------------------------------------
package csof_pkg;

	localparam logic [9:0] RADIUS_SPAN = 10'd250;
	localparam logic [9:0] WINDOW_SPAN = 10'd500;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [1:0] ADDR_OBSTACLE_COUNT = 2'd0;

	typedef struct packed {
		logic        func;
		logic [3:0]  slot;
		logic [8:0]  obstacle_x;
		logic [8:0]  obstacle_y;
		logic [5:0]  obstacle_radius;
		logic [28:0] seed_bits;
	} csof_in_t;

	typedef struct packed {
		logic [7:0] fitness;
		logic       overlaps;
		logic [8:0] circle_x;
		logic [8:0] circle_y;
		logic [7:0] circle_radius;
	} csof_out_t;

	// item as it travels along the cell chain; loads reuse x, y and r
	typedef struct packed {
		logic       eval;
		logic [3:0] slot;
		logic [8:0] x;
		logic [8:0] y;
		logic [7:0] r;
		logic       hit;
	} csof_item_t;

endpackage

// ----- src/csof_decode.sv -----
// ----------------------------------------------------------------------------
// csof_decode
// entry stage: unpacks the seed into a circle and forms the chain item
// ----------------------------------------------------------------------------
module csof_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  csof_pkg::csof_in_t  in_data,
	output logic                valid_out,
	output csof_pkg::csof_item_t item_out
);
	import csof_pkg::*;

	logic [8:0] r_abs;
	logic [9:0] y_abs;
	logic [9:0] x_raw;
	logic [7:0] r_mod;
	logic [8:0] y_mod;
	logic [8:0] x_mod;
	csof_item_t item_d;
	logic       valid_s1;
	csof_item_t item_s1;

	always_comb begin
		r_abs = in_data.seed_bits[8] ? 9'(~in_data.seed_bits[8:0] + 9'd1)
			: in_data.seed_bits[8:0];
		y_abs = in_data.seed_bits[18] ? 10'(~in_data.seed_bits[18:9] + 10'd1)
			: in_data.seed_bits[18:9];
		x_raw = in_data.seed_bits[28:19];

		r_mod = (10'(r_abs) >= RADIUS_SPAN) ? 8'(10'(r_abs) - RADIUS_SPAN) : 8'(r_abs);
		y_mod = (y_abs >= WINDOW_SPAN) ? 9'(y_abs - WINDOW_SPAN) : 9'(y_abs);
		// x spans up to 1023, just over twice the window, so two steps of reduction
		if (x_raw >= 10'(2 * 500))
			x_mod = 9'(x_raw - 10'(2 * 500));
		else if (x_raw >= WINDOW_SPAN)
			x_mod = 9'(x_raw - WINDOW_SPAN);
		else
			x_mod = 9'(x_raw);

		item_d.eval = (in_data.func == FUNC_EVAL);
		item_d.slot = in_data.slot;
		item_d.hit  = 1'b0;
		if (in_data.func == FUNC_EVAL) begin
			item_d.x = x_mod;
			item_d.y = y_mod;
			item_d.r = r_mod;
		end else begin
			item_d.x = in_data.obstacle_x;
			item_d.y = in_data.obstacle_y;
			item_d.r = 8'(in_data.obstacle_radius);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_d;
		end
	end

	assign valid_out = valid_s1;
	assign item_out  = item_s1;

endmodule

// ----- src/csof_cell.sv -----
// ----------------------------------------------------------------------------
// csof_cell
// one obstacle cell: holds one table slot and tests each passing seed
// ----------------------------------------------------------------------------
module csof_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [4:0]           obstacle_count,
	input  logic                 valid_in,
	input  csof_pkg::csof_item_t item_in,
	output logic                 valid_out,
	output csof_pkg::csof_item_t item_out
);
	import csof_pkg::*;

	localparam logic [7:0] CellIdx = 8'(CELL_INDEX);

	logic [8:0]  ox_q;
	logic [8:0]  oy_q;
	logic [5:0]  orad_q;

	logic        load_hit;
	logic        active;
	logic [8:0]  dx;
	logic [8:0]  dy;
	logic [8:0]  rs;
	logic [17:0] dx_sq;
	logic [17:0] dy_sq;
	logic [17:0] rs_sq;

	logic        valid_s1;
	logic        active_s1;
	csof_item_t  item_s1;
	logic [18:0] dist_s1;
	logic [17:0] reach_s1;
	csof_item_t  item_next;
	logic        valid_s2;
	csof_item_t  item_s2;

	always_comb begin
		load_hit = en && valid_in && !item_in.eval && (8'(item_in.slot) == CellIdx);
		active   = 8'(obstacle_count) > CellIdx;
		dx       = (item_in.x >= ox_q) ? 9'(item_in.x - ox_q) : 9'(ox_q - item_in.x);
		dy       = (item_in.y >= oy_q) ? 9'(item_in.y - oy_q) : 9'(oy_q - item_in.y);
		rs       = 9'(item_in.r) + 9'(orad_q);
		dx_sq    = 18'(dx) * 18'(dx);
		dy_sq    = 18'(dy) * 18'(dy);
		rs_sq    = 18'(rs) * 18'(rs);

		item_next     = item_s1;
		// touching circles do not count, hence strict compare
		item_next.hit = item_s1.hit
			| (active_s1 & item_s1.eval & (dist_s1 < 19'(reach_s1)));
	end

	// a load is captured as it passes, so older seeds ahead never see it
	always_ff @(posedge clk) begin
		if (load_hit) begin
			ox_q   <= item_in.x;
			oy_q   <= item_in.y;
			orad_q <= item_in.r[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1   <= item_in;
			active_s1 <= active;
			dist_s1   <= 19'(dx_sq) + 19'(dy_sq);
			reach_s1  <= rs_sq;
			item_s2   <= item_next;
		end
	end

	assign valid_out = valid_s2;
	assign item_out  = item_s2;

endmodule

// ----- src/circle_seed_overlap_fitness.sv -----
// ----------------------------------------------------------------------------
// circle_seed_overlap_fitness
// scores packed seed circles against a table of obstacle circles
// ----------------------------------------------------------------------------
// One item enters per cycle unless the chain stops. Every item passes
// a decode stage and then a chain of OBSTACLE_SLOTS obstacle cells, two
// register stages per cell, and an evaluate result is then captured in an
// output register. Load items travel the same chain and write their cell as
// they pass, so loads and evaluates keep their order. The chain stops only
// when an evaluate reaches its end while the output register still holds a
// result that has not been taken. A checked slot must be loaded before a seed
// is evaluated against it.
module circle_seed_overlap_fitness #(
	parameter int OBSTACLE_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                item_valid,
	output logic                item_ready,
	input  csof_pkg::csof_in_t  item,

	output logic                result_valid,
	input  logic                result_ready,
	output csof_pkg::csof_out_t result,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import csof_pkg::*;

	logic       en;
	logic [4:0] count_q;
	logic       cfg_write;

	logic       chain_valid [0:OBSTACLE_SLOTS];
	csof_item_t chain_item  [0:OBSTACLE_SLOTS];

	logic       last_eval;
	logic       result_load;
	logic       result_valid_q;
	csof_out_t  result_q;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == ADDR_OBSTACLE_COUNT);
	assign prdata    = (paddr == ADDR_OBSTACLE_COUNT) ? 32'(count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd0;
		end else if (cfg_write) begin
			count_q <= pwdata[4:0];
		end
	end

	// chain advances unless a finished evaluate would overrun a held result
	assign last_eval   = chain_valid[OBSTACLE_SLOTS] && chain_item[OBSTACLE_SLOTS].eval;
	assign en          = !(last_eval && result_valid_q && !result_ready);
	assign item_ready  = en;
	assign result_load = en && last_eval;

	csof_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.in_data   (item),
		.valid_out (chain_valid[0]),
		.item_out  (chain_item[0])
	);

	for (genvar i = 0; i < OBSTACLE_SLOTS; i++) begin : g_cell
		csof_cell #(
			.CELL_INDEX (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.en             (en),
			.obstacle_count (count_q),
			.valid_in       (chain_valid[i]),
			.item_in        (chain_item[i]),
			.valid_out      (chain_valid[i+1]),
			.item_out       (chain_item[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.overlaps      <= chain_item[OBSTACLE_SLOTS].hit;
			result_q.fitness       <= chain_item[OBSTACLE_SLOTS].hit ? 8'd1
				: chain_item[OBSTACLE_SLOTS].r;
			result_q.circle_x      <= chain_item[OBSTACLE_SLOTS].x;
			result_q.circle_y      <= chain_item[OBSTACLE_SLOTS].y;
			result_q.circle_radius <= chain_item[OBSTACLE_SLOTS].r;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_overlap_fitness: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.overlaps |-> result_q.fitness == 8'd1)
		else $error("overlapping result without fitness of one");

	a_clear_fitness: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.overlaps |-> result_q.fitness == result_q.circle_radius)
		else $error("fitness differs from radius without overlap");

	a_decoded_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.circle_x < 9'd500) && (result_q.circle_y < 9'd500)
			&& (result_q.circle_radius < 8'd250))
		else $error("decoded circle out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> result_valid_q)
		else $error("held result lost during chain stall");
`endif

endmodule
